>>> rtl/esd_pkg.sv
package esd_pkg;

    typedef logic [7:0] char_t;
    typedef logic [3:0] nibble_t;

    typedef struct packed {
        logic  ok;
        char_t val;
    } decode_t;

    localparam char_t CHAR_BACKSLASH = 8'h5c;
    localparam char_t CHAR_X         = 8'h78;
    localparam char_t CHAR_ZERO      = 8'h30;
    localparam char_t CHAR_NINE      = 8'h39;
    localparam char_t CHAR_SEVEN     = 8'h37;
    localparam char_t CHAR_LC_A      = 8'h61;
    localparam char_t CHAR_LC_F      = 8'h66;
    localparam char_t CHAR_UC_A      = 8'h41;
    localparam char_t CHAR_UC_F      = 8'h46;

    function automatic decode_t hex_digit(input char_t c);
        decode_t r;
        char_t   t;
        r = '0;
        t = '0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            r.ok  = 1'b1;
            r.val = c - CHAR_ZERO;
        end
        else if (c >= CHAR_LC_A && c <= CHAR_LC_F)
        begin
            t     = c - CHAR_LC_A;
            r.ok  = 1'b1;
            r.val = t + 8'd10;
        end
        else if (c >= CHAR_UC_A && c <= CHAR_UC_F)
        begin
            t     = c - CHAR_UC_A;
            r.ok  = 1'b1;
            r.val = t + 8'd10;
        end
        return r;
    endfunction

    function automatic decode_t oct_digit(input char_t c);
        decode_t r;
        r = '0;
        if (c >= CHAR_ZERO && c <= CHAR_SEVEN)
        begin
            r.ok  = 1'b1;
            r.val = c - CHAR_ZERO;
        end
        return r;
    endfunction

    function automatic decode_t simple_escape(input char_t c);
        decode_t r;
        r.ok = 1'b1;
        unique case (c)
            8'h61:   r.val = 8'd7;
            8'h62:   r.val = 8'd8;
            8'h66:   r.val = 8'd12;
            8'h6e:   r.val = 8'd10;
            8'h72:   r.val = 8'd13;
            8'h74:   r.val = 8'd9;
            8'h76:   r.val = 8'd11;
            8'h27, 8'h22, 8'h3f, 8'h5c: r.val = c;
            default:
            begin
                r.ok  = 1'b0;
                r.val = '0;
            end
        endcase
        return r;
    endfunction

endpackage

>>> rtl/esd_in_if.sv
interface esd_in_if import esd_pkg::*; ();

    logic  valid;
    logic  ready;
    char_t in_byte;
    logic  final_byte;

    modport source (output valid, output in_byte, output final_byte, input ready);
    modport sink   (input valid, input in_byte, input final_byte, output ready);

endinterface

>>> rtl/esd_out_if.sv
interface esd_out_if import esd_pkg::*; ();

    logic  valid;
    logic  ready;
    logic  out_valid;
    char_t out_byte;
    logic  string_end;

    modport source (output valid, output out_valid, output out_byte, output string_end,
                    input ready);
    modport sink   (input valid, input out_valid, input out_byte, input string_end,
                    output ready);

endinterface

>>> rtl/escape_sequence_decoder.sv
// escape sequence decoder
// in_ch carries one raw character per item (in_byte) and a last-character
// mark (final_byte). out_ch returns exactly one item per input item:
// out_valid says whether out_byte holds a decoded character (out_byte is
// zero otherwise) and string_end echoes final_byte.
// the result is registered and shows on out_ch in the cycle after input accept.
// throughput: one item per cycle; the decode state and the result register
// are both updated in the accepting cycle, so items may follow back to back.
// when the receiver stalls, the result register holds its item and in_ch
// stays ready only if that item is being taken in the same cycle.
// an escape still open after a character marked final_byte is dropped and
// decoding restarts in normal text mode.
// reset: decoding returns to normal text mode and the result register is
// emptied; no item is pending on out_ch after reset.
module escape_sequence_decoder import esd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    esd_in_if.sink    in_ch,
    esd_out_if.source out_ch
);

    localparam logic [2:0] MODE_TEXT = 3'd0;
    localparam logic [2:0] MODE_ESC  = 3'd1;
    localparam logic [2:0] MODE_HEX1 = 3'd2;
    localparam logic [2:0] MODE_HEX2 = 3'd3;
    localparam logic [2:0] MODE_OCT1 = 3'd4;
    localparam logic [2:0] MODE_OCT2 = 3'd5;

    logic [2:0] mode_reg;
    logic [2:0] mode_next;
    nibble_t    digit_val_reg;
    nibble_t    digit_val_next;
    logic       digit_ok_reg;
    logic       digit_ok_next;

    logic       res_full_reg;
    logic       res_valid_reg;
    char_t      res_byte_reg;
    logic       res_end_reg;

    logic       accept;
    logic       dec_valid;
    char_t      dec_byte;
    decode_t    hex_d;
    decode_t    oct_d;
    decode_t    esc_d;
    decode_t    dig_d;

    assign in_ch.ready = !res_full_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    assign hex_d = hex_digit(in_ch.in_byte);
    assign oct_d = oct_digit(in_ch.in_byte);
    assign esc_d = simple_escape(in_ch.in_byte);

    always_comb
    begin
        mode_next      = MODE_TEXT;
        digit_val_next = digit_val_reg;
        digit_ok_next  = digit_ok_reg;
        dec_valid      = 1'b0;
        dec_byte       = '0;
        dig_d          = '0;
        unique case (mode_reg)
            MODE_ESC:
            begin
                if (in_ch.in_byte == CHAR_X)
                    mode_next = MODE_HEX1;
                else if (in_ch.in_byte == CHAR_ZERO)
                    mode_next = MODE_OCT1;
                else
                begin
                    dec_valid = esc_d.ok;
                    dec_byte  = esc_d.val;
                end
            end
            MODE_HEX1, MODE_OCT1:
            begin
                dig_d          = (mode_reg == MODE_HEX1) ? hex_d : oct_d;
                digit_val_next = dig_d.val[3:0];
                digit_ok_next  = dig_d.ok;
                mode_next      = (mode_reg == MODE_HEX1) ? MODE_HEX2 : MODE_OCT2;
            end
            MODE_HEX2:
            begin
                dec_valid = 1'b1;
                if (!digit_ok_reg)
                    dec_byte = '0;
                else if (!hex_d.ok)
                    dec_byte = {4'd0, digit_val_reg};
                else
                    dec_byte = {digit_val_reg, hex_d.val[3:0]};
            end
            MODE_OCT2:
            begin
                dec_valid = 1'b1;
                if (!digit_ok_reg)
                    dec_byte = '0;
                else if (!oct_d.ok)
                    dec_byte = {4'd0, digit_val_reg};
                else
                    dec_byte = {2'd0, digit_val_reg[2:0], oct_d.val[2:0]};
            end
            default:
            begin
                if (in_ch.in_byte == CHAR_BACKSLASH)
                    mode_next = MODE_ESC;
                else
                begin
                    dec_valid = 1'b1;
                    dec_byte  = in_ch.in_byte;
                end
            end
        endcase
        if (in_ch.final_byte)
            mode_next = MODE_TEXT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_TEXT;
            digit_val_reg <= '0;
            digit_ok_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            digit_val_reg <= digit_val_next;
            digit_ok_reg  <= digit_ok_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_full_reg <= 1'b0;
        else if (accept)
            res_full_reg <= 1'b1;
        else if (out_ch.ready)
            res_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_valid_reg <= dec_valid;
            res_byte_reg  <= dec_valid ? dec_byte : '0;
            res_end_reg   <= in_ch.final_byte;
        end
    end

    assign out_ch.valid      = res_full_reg;
    assign out_ch.out_valid  = res_valid_reg;
    assign out_ch.out_byte   = res_byte_reg;
    assign out_ch.string_end = res_end_reg;

    // a result without a decoded character carries a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.out_valid) |-> (out_ch.out_byte == '0))
        else $error("empty result with nonzero byte");

    // the last character of a string always closes any open escape
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.final_byte) |=> (mode_reg == MODE_TEXT))
        else $error("escape left open past end of string");

    // only the six defined modes are ever reached
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg <= MODE_OCT2))
        else $error("undefined decode mode");

    // a held result blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
        else $error("input taken while result stalled");

    // every accepted item shows a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (out_ch.valid && out_ch.string_end == $past(in_ch.final_byte)))
        else $error("result missing after accept");

endmodule
